FILE: rtl/mfek_pkg.sv
// Package for the max flow block: sizes, payload structs, controller commands and flags.
// Used by mfek_ctrl, mfek_dp and max_flow_edmonds_karp; depends on nothing.
package mfek_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int CNT_W     = 7;
    localparam int CAP_BITS  = 16;
    localparam int RES_W     = 17;
    localparam int FLOW_W    = 22;
    localparam int ADDR_W    = 12;
    localparam int IDX_W     = 13;

    localparam logic [FLOW_W-1:0] FLOW_MAX         = 22'h3fffff;
    localparam logic [27:0]       BOTTLENECK_START = 28'hfffffff;
    localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = 7'd64;
    localparam logic [CNT_W-1:0]  NODE_LIMIT       = 7'd64;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] REG_NODE_COUNT = 3'd0;

    // Operation codes of an input item.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [15:0]       capacity;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] sink_node;
    } t_in_item;

    typedef struct packed {
        logic [FLOW_W-1:0] total_flow;
        logic              status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_RUN,
        CMD_COPY,
        CMD_BFS_INIT,
        CMD_POP,
        CMD_LOAD_U,
        CMD_SCAN,
        CMD_WALK_INIT,
        CMD_RD_PARENT,
        CMD_RD_FWD,
        CMD_CMP,
        CMD_SUB,
        CMD_ADD
    } t_cmd;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic run_err;
        logic copy_done;
        logic q_empty;
        logic scan_done;
        logic found;
        logic at_src;
    } t_dp_flags;

endpackage

FILE: rtl/mfek_dp.sv
// Datapath of the max flow block: capacity and residual matrices, search queue,
// parent table, visited marks, bottleneck and flow registers. Uses mfek_pkg.
module mfek_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mfek_pkg::t_cmd              i_cmd,
    input  mfek_pkg::t_in_item          i_item,
    input  logic [mfek_pkg::CNT_W-1:0]  i_nodes,
    output mfek_pkg::t_dp_flags         o_flags,
    output mfek_pkg::t_out_item         o_result
);

    // Storage.
    logic [mfek_pkg::CAP_BITS-1:0] r_cap_mem [4096];
    logic [mfek_pkg::RES_W-1:0]    r_res_mem [4096];
    logic [mfek_pkg::NODE_W-1:0]   r_par_mem [mfek_pkg::MAX_NODES];
    logic [mfek_pkg::NODE_W-1:0]   r_q_mem   [mfek_pkg::MAX_NODES];
    logic [mfek_pkg::MAX_NODES-1:0] r_visited;

    logic [mfek_pkg::CAP_BITS-1:0] r_cap_q;
    logic [mfek_pkg::RES_W-1:0]    r_res_q;
    logic [mfek_pkg::NODE_W-1:0]   r_par_q;
    logic [mfek_pkg::NODE_W-1:0]   r_q_q;

    // Control and working registers.
    logic [mfek_pkg::IDX_W-1:0]  r_idx;
    logic                        r_cp_vld;
    logic [mfek_pkg::ADDR_W-1:0] r_cp_addr;
    logic [mfek_pkg::NODE_W-1:0] r_src, r_dst, r_u, r_w, r_vd;
    logic [mfek_pkg::CNT_W-1:0]  r_n, r_v, r_head, r_tail;
    logic                        r_pend;
    logic                        r_err;
    logic [27:0]                 r_bneck;
    logic [mfek_pkg::FLOW_W-1:0] r_total;

    logic                         cap_we;
    logic [mfek_pkg::ADDR_W-1:0]  cap_waddr;
    logic [mfek_pkg::CAP_BITS-1:0] cap_wdata;
    logic                         res_we;
    logic [mfek_pkg::ADDR_W-1:0]  res_waddr, res_raddr;
    logic [mfek_pkg::RES_W-1:0]   res_wdata;
    logic                         push;
    logic                         run_bad;
    logic [mfek_pkg::FLOW_W:0]    sum;

    assign push = (i_cmd == mfek_pkg::CMD_SCAN) && r_pend && !r_visited[r_vd]
                  && (r_res_q != '0);
    assign run_bad = (i_item.source_node == i_item.sink_node)
                  || ({1'b0, i_item.source_node} >= i_nodes)
                  || ({1'b0, i_item.sink_node} >= i_nodes);
    assign sum = {1'b0, r_total} + (mfek_pkg::FLOW_W + 1)'(r_bneck[mfek_pkg::RES_W-1:0]);

    // Capacity matrix port selection.
    always_comb begin
        cap_we    = 1'b0;
        cap_waddr = {i_item.from_node, i_item.to_node};
        cap_wdata = i_item.capacity;
        if (i_cmd == mfek_pkg::CMD_CLEAR) begin
            cap_we    = 1'b1;
            cap_waddr = r_idx[mfek_pkg::ADDR_W-1:0];
            cap_wdata = '0;
        end else if (i_cmd == mfek_pkg::CMD_LOAD) begin
            cap_we = 1'b1;
        end
    end

    // Residual matrix port selection.
    always_comb begin
        res_we    = 1'b0;
        res_waddr = r_cp_addr;
        res_wdata = {1'b0, r_cap_q};
        res_raddr = {r_u, r_v[mfek_pkg::NODE_W-1:0]};
        unique case (i_cmd)
            mfek_pkg::CMD_COPY: begin
                res_we = r_cp_vld;
            end
            mfek_pkg::CMD_RD_FWD: begin
                res_raddr = {r_par_q, r_w};
            end
            mfek_pkg::CMD_SUB: begin
                res_we    = 1'b1;
                res_waddr = {r_u, r_w};
                res_wdata = r_res_q - r_bneck[mfek_pkg::RES_W-1:0];
                res_raddr = {r_w, r_u};
            end
            mfek_pkg::CMD_ADD: begin
                res_we    = 1'b1;
                res_waddr = {r_w, r_u};
                res_wdata = r_res_q + r_bneck[mfek_pkg::RES_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (cap_we) begin
            r_cap_mem[cap_waddr] <= cap_wdata;
        end
        r_cap_q <= r_cap_mem[r_idx[mfek_pkg::ADDR_W-1:0]];
        if (res_we) begin
            r_res_mem[res_waddr] <= res_wdata;
        end
        r_res_q <= r_res_mem[res_raddr];
        if (push) begin
            r_par_mem[r_vd] <= r_u;
        end
        r_par_q <= r_par_mem[r_w];
        if (i_cmd == mfek_pkg::CMD_BFS_INIT) begin
            r_q_mem[0] <= r_src;
        end else if (push) begin
            r_q_mem[r_tail[mfek_pkg::NODE_W-1:0]] <= r_vd;
        end
        r_q_q <= r_q_mem[r_head[mfek_pkg::NODE_W-1:0]];
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cp_vld  <= 1'b0;
            r_pend    <= 1'b0;
            r_visited <= '0;
            r_err     <= 1'b0;
            r_total   <= '0;
        end else begin
            unique case (i_cmd)
                mfek_pkg::CMD_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                end
                mfek_pkg::CMD_RUN: begin
                    r_src   <= i_item.source_node;
                    r_dst   <= i_item.sink_node;
                    r_n     <= i_nodes;
                    r_err   <= run_bad;
                    r_total <= '0;
                    r_idx   <= '0;
                    r_cp_vld <= 1'b0;
                end
                mfek_pkg::CMD_COPY: begin
                    r_cp_vld  <= !r_idx[mfek_pkg::IDX_W-1];
                    r_cp_addr <= r_idx[mfek_pkg::ADDR_W-1:0];
                    if (!r_idx[mfek_pkg::IDX_W-1]) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                mfek_pkg::CMD_BFS_INIT: begin
                    r_visited <= {{(mfek_pkg::MAX_NODES-1){1'b0}}, 1'b1} << r_src;
                    r_head    <= '0;
                    r_tail    <= 7'd1;
                end
                mfek_pkg::CMD_POP: begin
                    if (r_head != r_tail) begin
                        r_head <= r_head + 1'b1;
                    end
                end
                mfek_pkg::CMD_LOAD_U: begin
                    r_u    <= r_q_q;
                    r_v    <= '0;
                    r_pend <= 1'b0;
                end
                mfek_pkg::CMD_SCAN: begin
                    r_pend <= (r_v < r_n);
                    r_vd   <= r_v[mfek_pkg::NODE_W-1:0];
                    if (r_v < r_n) begin
                        r_v <= r_v + 1'b1;
                    end
                    if (push) begin
                        r_visited[r_vd] <= 1'b1;
                        r_tail          <= r_tail + 1'b1;
                    end
                end
                mfek_pkg::CMD_WALK_INIT: begin
                    r_w     <= r_dst;
                    r_bneck <= mfek_pkg::BOTTLENECK_START;
                end
                mfek_pkg::CMD_RD_FWD: begin
                    r_u <= r_par_q;
                end
                mfek_pkg::CMD_CMP: begin
                    if (28'(r_res_q) < r_bneck) begin
                        r_bneck <= 28'(r_res_q);
                    end
                    r_w <= (r_u == r_src) ? r_dst : r_u;
                end
                mfek_pkg::CMD_ADD: begin
                    r_w <= r_u;
                    if (r_u == r_src) begin
                        r_total <= sum[mfek_pkg::FLOW_W] ? mfek_pkg::FLOW_MAX
                                                         : sum[mfek_pkg::FLOW_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Status toward the controller and the result.
    assign o_flags.clr_done  = (r_idx[mfek_pkg::ADDR_W-1:0] == '1);
    assign o_flags.run_err   = r_err;
    assign o_flags.copy_done = r_idx[mfek_pkg::IDX_W-1] && !r_cp_vld;
    assign o_flags.q_empty   = (r_head == r_tail);
    assign o_flags.scan_done = (r_v >= r_n) && !r_pend;
    assign o_flags.found     = r_visited[r_dst];
    assign o_flags.at_src    = (r_u == r_src);

    assign o_result.total_flow = r_err ? '0 : r_total;
    assign o_result.status     = r_err;

endmodule

FILE: rtl/mfek_ctrl.sv
// Controller of the max flow block: sequences clearing, loads, copy, search,
// bottleneck walk and augmentation. Uses mfek_pkg.
module mfek_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_op,
    input  mfek_pkg::t_dp_flags i_flags,
    output mfek_pkg::t_cmd      o_cmd,
    output logic                o_busy,
    output logic                o_done
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_COPY, S_BFS_INIT, S_POP, S_POP_WAIT, S_SCAN,
        S_PATH, S_B1, S_B2, S_B3, S_A1, S_A2, S_A3, S_A4, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_done;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = mfek_pkg::CMD_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd = mfek_pkg::CMD_CLEAR;
                if (i_flags.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start && !r_busy) begin
                    if (i_op == mfek_pkg::OP_RUN) begin
                        o_cmd   = mfek_pkg::CMD_RUN;
                        n_state = S_CHECK;
                    end else begin
                        o_cmd = mfek_pkg::CMD_LOAD;
                    end
                end
            end
            S_CHECK: begin
                n_state = i_flags.run_err ? S_DONE : S_COPY;
            end
            S_COPY: begin
                o_cmd = mfek_pkg::CMD_COPY;
                if (i_flags.copy_done) n_state = S_BFS_INIT;
            end
            S_BFS_INIT: begin
                o_cmd   = mfek_pkg::CMD_BFS_INIT;
                n_state = S_POP;
            end
            S_POP: begin
                o_cmd   = mfek_pkg::CMD_POP;
                n_state = i_flags.q_empty ? S_PATH : S_POP_WAIT;
            end
            S_POP_WAIT: begin
                o_cmd   = mfek_pkg::CMD_LOAD_U;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd = mfek_pkg::CMD_SCAN;
                if (i_flags.scan_done) n_state = S_POP;
            end
            S_PATH: begin
                o_cmd   = mfek_pkg::CMD_WALK_INIT;
                n_state = i_flags.found ? S_B1 : S_DONE;
            end
            S_B1: begin
                o_cmd   = mfek_pkg::CMD_RD_PARENT;
                n_state = S_B2;
            end
            S_B2: begin
                o_cmd   = mfek_pkg::CMD_RD_FWD;
                n_state = S_B3;
            end
            S_B3: begin
                o_cmd   = mfek_pkg::CMD_CMP;
                n_state = i_flags.at_src ? S_A1 : S_B1;
            end
            S_A1: begin
                o_cmd   = mfek_pkg::CMD_RD_PARENT;
                n_state = S_A2;
            end
            S_A2: begin
                o_cmd   = mfek_pkg::CMD_RD_FWD;
                n_state = S_A3;
            end
            S_A3: begin
                o_cmd   = mfek_pkg::CMD_SUB;
                n_state = S_A4;
            end
            S_A4: begin
                o_cmd   = mfek_pkg::CMD_ADD;
                n_state = i_flags.at_src ? S_BFS_INIT : S_A1;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (n_state == S_DONE);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

    // The result strobe falls in a busy cycle, never while an item could enter.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_busy) else $error("result strobe outside a run");

    // A finished neighbor scan always returns to the queue.
    a_scan_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_flags.scan_done) |=> (r_state == S_POP))
        else $error("scan did not return to pop");

    // Reset starts the clearing pass.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR && r_busy))
        else $error("reset did not start clearing");

endmodule

FILE: rtl/max_flow_edmonds_karp.sv
// Top level of the Edmonds-Karp max flow block: configuration port and the
// controller and datapath. Uses mfek_pkg, mfek_ctrl and mfek_dp.
//
// A load item writes one capacity; busy stays low. A run item raises busy and
// later gives one result with o_done high for exactly one cycle; the receiver
// cannot stall it. An error case ends the run after its check; otherwise the
// run copies the capacity matrix into the residual matrix and then, for each
// augmenting path, runs a breadth-first search, one residual matrix read per
// cycle, followed by the bottleneck walk and update along the path.
// After reset the capacity matrix is cleared with busy high.
module max_flow_edmonds_karp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  mfek_pkg::t_in_item  i_item,
    output logic                o_done,
    output mfek_pkg::t_out_item o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [mfek_pkg::CNT_W-1:0] r_node_count;
    logic [mfek_pkg::CNT_W-1:0] nodes;
    mfek_pkg::t_cmd             cmd;
    mfek_pkg::t_dp_flags        flags;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= mfek_pkg::NODE_COUNT_RESET;
        end else if (psel && penable && pwrite && paddr == mfek_pkg::REG_NODE_COUNT) begin
            r_node_count <= pwdata[mfek_pkg::CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == mfek_pkg::REG_NODE_COUNT) ? 32'(r_node_count) : '0;
    assign nodes  = (r_node_count > mfek_pkg::NODE_LIMIT) ? mfek_pkg::NODE_LIMIT
                                                          : r_node_count;

    mfek_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.operation),
        .i_flags (flags),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    mfek_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .i_nodes  (nodes),
        .o_flags  (flags),
        .o_result (o_result)
    );

endmodule

FILE: test/max_flow_edmonds_karp_tb.sv
// Testbench for max_flow_edmonds_karp: edge loads and max flow runs checked
// against an in-bench Edmonds-Karp predictor. Depends on mfek_pkg and the RTL.
module max_flow_edmonds_karp_tb;

    localparam int IDLE_LIMIT = 600000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    mfek_pkg::t_in_item   i_item = '0;
    logic                 o_done;
    mfek_pkg::t_out_item  o_result;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    max_flow_edmonds_karp DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: capacity matrix and node count register.
    logic [mfek_pkg::CAP_BITS-1:0] cap_mem [mfek_pkg::MAX_NODES][mfek_pkg::MAX_NODES];
    logic [mfek_pkg::CNT_W-1:0]    node_cnt;
    mfek_pkg::t_out_item           flow_expected [$];

    int gap_pct = 0;
    int mismatches = 0;
    int runs_sent = 0;
    int loads_sent = 0;
    int idle_cycles = 0;

    // Edmonds-Karp over a copy of the capacity matrix.
    function automatic mfek_pkg::t_out_item predict_flow(logic [mfek_pkg::NODE_W-1:0] s,
                                                         logic [mfek_pkg::NODE_W-1:0] t);
        mfek_pkg::t_out_item r;
        int unsigned resid [mfek_pkg::MAX_NODES][mfek_pkg::MAX_NODES];
        int          par [mfek_pkg::MAX_NODES];
        bit          seen [mfek_pkg::MAX_NODES];
        int          fifo [mfek_pkg::MAX_NODES];
        int          n, head, tail, u, v;
        longint      total;
        int unsigned bneck;
        n = (node_cnt > mfek_pkg::NODE_LIMIT) ? mfek_pkg::MAX_NODES : int'(node_cnt);
        r = '0;
        if (s == t || int'(s) >= n || int'(t) >= n) begin
            r.status = 1'b1;
            return r;
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                resid[i][j] = 32'(cap_mem[i][j]);
        total = 0;
        forever begin
            // Breadth-first search for a shortest augmenting path.
            for (int i = 0; i < mfek_pkg::MAX_NODES; i++) seen[i] = 1'b0;
            seen[s] = 1'b1;
            head = 0;
            tail = 0;
            fifo[tail++] = int'(s);
            while (head < tail) begin
                u = fifo[head++];
                for (v = 0; v < n; v++) begin
                    if (!seen[v] && resid[u][v] > 0) begin
                        seen[v] = 1'b1;
                        par[v] = u;
                        if (tail < mfek_pkg::MAX_NODES) fifo[tail++] = v;
                    end
                end
            end
            if (!seen[t]) break;
            bneck = 32'(mfek_pkg::BOTTLENECK_START);
            for (v = int'(t); v != int'(s); v = par[v])
                if (resid[par[v]][v] < bneck) bneck = resid[par[v]][v];
            for (v = int'(t); v != int'(s); v = par[v]) begin
                resid[par[v]][v] -= bneck;
                resid[v][par[v]] += bneck;
            end
            total += longint'(bneck);
            if (total > longint'(mfek_pkg::FLOW_MAX)) total = longint'(mfek_pkg::FLOW_MAX);
        end
        r.total_flow = total[mfek_pkg::FLOW_W-1:0];
        return r;
    endfunction

    // Send one item, with a random gap before it in the current idling mode.
    task automatic send_item(mfek_pkg::t_in_item it);
        if ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk) start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        start = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (it.operation == mfek_pkg::OP_RUN) begin
            flow_expected.push_back(predict_flow(it.source_node, it.sink_node));
            runs_sent++;
        end else begin
            cap_mem[it.from_node][it.to_node] = it.capacity;
            loads_sent++;
        end
    endtask

    task automatic load_edge(int a, int b, int c);
        mfek_pkg::t_in_item it;
        it = '0;
        it.operation = mfek_pkg::OP_LOAD;
        it.from_node = a[mfek_pkg::NODE_W-1:0];
        it.to_node = b[mfek_pkg::NODE_W-1:0];
        it.capacity = c[15:0];
        send_item(it);
    endtask

    task automatic run_flow(int s, int t);
        mfek_pkg::t_in_item it;
        logic [63:0]        noise;
        noise = {$urandom, $urandom};
        it = noise[$bits(mfek_pkg::t_in_item)-1:0];
        it.operation = mfek_pkg::OP_RUN;
        it.source_node = s[mfek_pkg::NODE_W-1:0];
        it.sink_node = t[mfek_pkg::NODE_W-1:0];
        send_item(it);
    endtask

    // Stop sending and wait until the block is idle with nothing expected.
    task automatic drain;
        @(negedge i_clk) start = 1'b0;
        while (flow_expected.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Write the node count register by an APB setup and access cycle.
    task automatic write_node_count(logic [31:0] val);
        drain();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = mfek_pkg::REG_NODE_COUNT;
        pwdata = val;
        @(negedge i_clk) penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        node_cnt = val[mfek_pkg::CNT_W-1:0];
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (flow_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: flow %0d status %0d",
                             o_result.total_flow, o_result.status);
            end else begin
                mfek_pkg::t_out_item exp_r;
                exp_r = flow_expected.pop_front();
                if (o_result.total_flow !== exp_r.total_flow
                    || o_result.status !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected flow %0d status %0d, got flow %0d status %0d",
                                 exp_r.total_flow, exp_r.status,
                                 o_result.total_flow, o_result.status);
                end
            end
        end
    end

    // Watchdog on cycles in which nothing is accepted.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable && pwrite && pready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    // Extremes of fields, error cases, self-loops and out-of-range loads.
    task automatic test_directed;
        write_node_count(8);
        load_edge(0, 1, 65535);
        load_edge(1, 7, 300);
        load_edge(0, 7, 0);
        load_edge(3, 3, 500);
        load_edge(0, 3, 77);
        load_edge(3, 7, 50);
        load_edge(63, 63, 65535);
        load_edge(63, 0, 1234);
        load_edge(10, 7, 999);
        run_flow(0, 7);
        run_flow(7, 0);
        run_flow(3, 3);
        run_flow(0, 8);
        run_flow(63, 0);
        run_flow(0, 63);
        load_edge(0, 1, 0);
        run_flow(0, 7);
        // Wider count covers the node loaded earlier out of range.
        write_node_count(12);
        load_edge(0, 10, 40);
        run_flow(0, 7);
        write_node_count(1);
        run_flow(0, 1);
        write_node_count(0);
        run_flow(0, 0);
        write_node_count(127);
        run_flow(63, 0);
        write_node_count(2);
        run_flow(0, 1);
        run_flow(1, 0);
    endtask

    // Many parallel full-capacity paths drive the flow into its high bits.
    task automatic test_wide_flow;
        write_node_count(64);
        for (int k = 1; k <= 33; k++) begin
            load_edge(0, k, 65535);
            load_edge(k, 63, 65535);
        end
        run_flow(0, 63);
    endtask

    // Random small graphs: mostly well-formed loads and runs, some noise.
    task automatic test_random(int items);
        int n, sent, a, b, c;
        sent = 0;
        while (sent < items) begin
            n = $urandom_range(3, 10);
            write_node_count(n);
            repeat ($urandom_range(3, 8)) begin
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                if ($urandom_range(9) == 0) a = $urandom_range(0, 63);
                if ($urandom_range(9) == 0) b = $urandom_range(0, 63);
                case ($urandom_range(3))
                    0: c = $urandom_range(0, 65535);
                    1: c = 65535 - $urandom_range(0, 3);
                    default: c = $urandom_range(0, 40);
                endcase
                load_edge(a, b, c);
                sent++;
            end
            repeat ($urandom_range(1, 3)) begin
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                if ($urandom_range(7) == 0) b = $urandom_range(0, 63);
                run_flow(a, b);
                sent++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < mfek_pkg::MAX_NODES; i++)
            for (int j = 0; j < mfek_pkg::MAX_NODES; j++)
                cap_mem[i][j] = '0;
        node_cnt = mfek_pkg::NODE_COUNT_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        gap_pct = 24;
        test_directed();
        test_wide_flow();
        test_random(15);
        gap_pct = 80;
        test_random(15);
        gap_pct = 0;
        test_random(10);
        drain();
        repeat (20) @(negedge i_clk);
        $display("Covered %0d edge loads and %0d flow runs over node counts 0 to 127.",
                 loads_sent, runs_sent);
        $display("Mismatches counted: %0d", mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
